// File: design/aes_pkg.sv
// AES-128 package: payload and key-state types, S-box and round helpers.
// No dependencies; used by every module of the encryptor.
`timescale 1ns / 1ps
package aes_pkg;

	localparam int unsigned NumRounds = 10;

	typedef enum logic {
		CFG_KEY_LOW  = 1'b0,
		CFG_KEY_HIGH = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [63:0] plain_high;
		logic [63:0] plain_low;
	} aes_in_t;

	typedef struct packed {
		logic [63:0] cipher_high;
		logic [63:0] cipher_low;
	} aes_out_t;

	// State and key travelling together down the round chain
	typedef struct packed {
		logic         vld;
		logic [127:0] state;
		logic [127:0] rkey;
		logic [7:0]   rcon;
	} aes_stage_t;

	function automatic logic [7:0] sbox(input logic [7:0] b);
		logic [7:0] r;
		case (b)
			8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
			8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
			8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
			8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
			8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
			8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
			8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
			8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
			8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
			8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
			8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
			8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
			8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
			8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
			8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
			8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
			8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
			8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
			8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
			8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
			8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
			8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
			8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
			8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
			8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
			8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
			8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
			8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
			8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
			8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
			8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
			8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
			8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
			8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
			8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
			8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
			8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
			8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
			8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
			8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
			8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
			8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
			8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
			8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
			8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
			8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
			8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
			8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
			8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
			8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
			8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
			8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
			8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
			8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
			8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
			8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
			8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
			8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
			8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
			8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
			8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
			8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
			8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
			8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Multiply by x in GF(2^8)
	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

// File: design/aes_round_cell.sv
// One AES round cell: SubBytes, ShiftRows, optional MixColumns, key step.
// Depends on aes_pkg. Registered output hands to the next cell.
`timescale 1ns / 1ps
module aes_round_cell import aes_pkg::*; #(
	parameter bit LastRound = 1'b0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  aes_stage_t din,
	output aes_stage_t dout
);

	logic [7:0]   s   [16];
	logic [7:0]   k   [16];
	logic [7:0]   t   [16];
	logic [7:0]   m   [16];
	logic [7:0]   nk  [16];
	logic [127:0] st_next;
	logic [127:0] rk_next;
	aes_stage_t   cell_q;

	// Byte view of the incoming state and key
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			s[i] = din.state[8*i +: 8];
			k[i] = din.rkey[8*i +: 8];
		end
	end

	// SubBytes with ShiftRows: row r of column c from column c+r
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[4*c+r] = sbox(s[4*((c+r)%4)+r]);
			end
		end
	end

	// MixColumns, bypassed in the last round
	always_comb begin
		logic [7:0] a0, a1, a2, a3, al;
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
			al = a0 ^ a1 ^ a2 ^ a3;
			if (LastRound) begin
				m[4*c] = a0; m[4*c+1] = a1; m[4*c+2] = a2; m[4*c+3] = a3;
			end else begin
				m[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
				m[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
				m[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
				m[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
			end
		end
	end

	// Key expansion step; word chain unrolled over four words
	always_comb begin
		nk[0] = k[0] ^ sbox(k[13]) ^ din.rcon;
		nk[1] = k[1] ^ sbox(k[14]);
		nk[2] = k[2] ^ sbox(k[15]);
		nk[3] = k[3] ^ sbox(k[12]);
		for (int i = 4; i < 16; i++) begin
			nk[i] = k[i] ^ nk[i-4];
		end
		for (int i = 0; i < 16; i++) begin
			rk_next[8*i +: 8] = nk[i];
			st_next[8*i +: 8] = m[i] ^ nk[i];
		end
	end

	// Cell register: valid, state, round key and round constant
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else begin
			cell_q.vld   <= din.vld;
			cell_q.state <= st_next;
			cell_q.rkey  <= rk_next;
			cell_q.rcon  <= xtime(din.rcon);
		end
	end

	assign dout = cell_q;

endmodule

// File: design/aes128_block_encrypt.sv
// AES-128 encryptor: key registers, input whitening and a chain of ten round cells.
// Whitening register, then the cells; one block accepted every cycle, busy stays low.
// Each round cell holds one block and its round key; the chain advances every cycle.
// Reset clears the key registers to zero and empties the chain; results cannot be stalled.
// Depends on aes_pkg and aes_round_cell.
`timescale 1ns / 1ps
module aes128_block_encrypt import aes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  aes_in_t     din,
	output logic        done,
	output aes_out_t    dout,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [63:0] cfg_data
);

	logic [63:0] key_lo_q;
	logic [63:0] key_hi_q;
	aes_stage_t  chain [NumRounds+1];

	// Key register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q <= '0;
			key_hi_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_KEY_LOW:  key_lo_q <= cfg_data;
				CFG_KEY_HIGH: key_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Initial AddRoundKey feeds the first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain[0] <= '0;
		end else begin
			chain[0].vld   <= start;
			chain[0].state <= {din.plain_high ^ key_hi_q, din.plain_low ^ key_lo_q};
			chain[0].rkey  <= {key_hi_q, key_lo_q};
			chain[0].rcon  <= 8'h01;
		end
	end

	for (genvar g = 0; g < NumRounds; g++) begin : g_round
		aes_round_cell #(
			.LastRound(g == NumRounds - 1)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.din   (chain[g]),
			.dout  (chain[g+1])
		);
	end

	assign busy = 1'b0;
	assign done = chain[NumRounds].vld;
	assign dout = {chain[NumRounds].state[127:64], chain[NumRounds].state[63:0]};

endmodule

// File: tb/sv/tb_aes128_block_encrypt.sv
// Self-checking bench for the AES-128 block encryptor: directed vectors, then random traffic.
// Depends on aes_pkg and the aes128_block_encrypt RTL; ciphertext predicted locally.
`timescale 1ns / 1ps
module tb_aes128_block_encrypt import aes_pkg::*;;

	localparam int LATENCY = 11;
	localparam int CYCLE_LIMIT = 200000;
	localparam int NUM_DIRECTED = 8;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	aes_in_t     din;
	logic        done;
	aes_out_t    dout;
	logic        cfg_we;
	logic        cfg_idx;
	logic [63:0] cfg_data;

	aes128_block_encrypt dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .din(din),
		.done(done), .dout(dout), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// Local key copy and pending ciphertexts
	logic [63:0] key_lo_q, key_hi_q;
	aes_out_t    pending_cipher[$];
	int          mismatches, blocks_sent, blocks_seen, cycles;
	int          send_idle_pct;

	logic [7:0] sb_tab[256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// Directed rows: key, plaintext, and typed-in ciphertext where well known
	typedef struct {
		logic [63:0] k_lo, k_hi;
		aes_in_t     blk;
		logic        known;
		aes_out_t    cipher;
	} vector_t;

	vector_t vectors[NUM_DIRECTED];

	initial begin
		// all-zero key and block, straight after reset
		vectors[0] = '{64'h0, 64'h0, '0, 1'b1, '{64'h2e2b34ca59fa4c88, 64'h3b2c8aefd44be966}};
		// FIPS-197 appendix C.1 vector
		vectors[1] = '{64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
			'{64'hffeeddccbbaa9988, 64'h7766554433221100}, 1'b1,
			'{64'h5ac5b47080b7cdd8, 64'h30047b6ad8e0c469}};
		vectors[2] = '{'1, '1, '1, 1'b0, '0};
		vectors[3] = '{'1, '1, '0, 1'b0, '0};
		vectors[4] = '{'0, '1, '{64'h0, 64'hffffffffffffffff}, 1'b0, '0};
		vectors[5] = '{'1, '0, '{64'hffffffffffffffff, 64'h0}, 1'b0, '0};
		vectors[6] = '{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555,
			'{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa}, 1'b0, '0};
		vectors[7] = '{64'h8000000000000001, 64'h0000000000000080,
			'{64'h0000000000000001, 64'h8000000000000000}, 1'b0, '0};
	end

	function automatic logic [7:0] gf_dbl(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// Full AES-128 encryption with the round key expanded alongside the state
	function automatic aes_out_t encrypt_block(input aes_in_t blk, input logic [63:0] k_lo,
			input logic [63:0] k_hi);
		logic [7:0] st[16], rk[16], tmp[16], t4[4];
		logic [7:0] rc, a0, a1, a2, a3, all;
		aes_out_t res;
		rc = 8'h01;
		for (int i = 0; i < 8; i++) begin
			st[i] = blk.plain_low[8*i +: 8];
			st[8+i] = blk.plain_high[8*i +: 8];
			rk[i] = k_lo[8*i +: 8];
			rk[8+i] = k_hi[8*i +: 8];
		end
		for (int i = 0; i < 16; i++) st[i] ^= rk[i];
		for (int rnd = 1; rnd <= 10; rnd++) begin
			// sub-bytes and row shift
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					tmp[4*c+r] = sb_tab[st[4*((c+r)%4)+r]];
			st = tmp;
			if (rnd != 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
					all = a0 ^ a1 ^ a2 ^ a3;
					st[4*c]   = a0 ^ all ^ gf_dbl(a0 ^ a1);
					st[4*c+1] = a1 ^ all ^ gf_dbl(a1 ^ a2);
					st[4*c+2] = a2 ^ all ^ gf_dbl(a2 ^ a3);
					st[4*c+3] = a3 ^ all ^ gf_dbl(a3 ^ a0);
				end
			end
			// next round key
			t4[0] = sb_tab[rk[13]] ^ rc;
			t4[1] = sb_tab[rk[14]];
			t4[2] = sb_tab[rk[15]];
			t4[3] = sb_tab[rk[12]];
			for (int i = 0; i < 4; i++) rk[i] ^= t4[i];
			for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
			for (int i = 0; i < 16; i++) st[i] ^= rk[i];
			rc = gf_dbl(rc);
		end
		for (int i = 0; i < 8; i++) begin
			res.cipher_low[8*i +: 8] = st[i];
			res.cipher_high[8*i +: 8] = st[8+i];
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		$display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
	endtask

	// Clock and cycle guard
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Result checker
	always @(posedge clk) begin
		aes_out_t want;
		if (arst_n && done) begin
			blocks_seen++;
			if (pending_cipher.size() == 0) begin
				report_mismatch("unexpected result", dout.cipher_low, '0);
			end else begin
				want = pending_cipher.pop_front();
				if (dout.cipher_low !== want.cipher_low)
					report_mismatch("cipher_low", dout.cipher_low, want.cipher_low);
				if (dout.cipher_high !== want.cipher_high)
					report_mismatch("cipher_high", dout.cipher_high, want.cipher_high);
			end
		end
	end

	task automatic write_key(input cfg_index_t idx, input logic [63:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_KEY_LOW) key_lo_q = value;
		else key_hi_q = value;
	endtask

	// Wait for the pipeline to drain before a key change or the end
	task automatic drain_pipeline();
		while (pending_cipher.size() != 0) @(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	// Offer one block; called at a falling edge, returns at a falling edge after transfer
	task automatic send_block(input aes_in_t blk, input aes_out_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		din = blk;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_cipher.push_back(want);
		blocks_sent++;
		@(negedge clk);
		start = 1'b0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	initial begin
		aes_in_t blk;
		int idle_plan[4] = '{0, 81, 0, 30};
		arst_n = 1'b0;
		start = 1'b0;
		din = '0;
		cfg_we = 1'b0;
		cfg_idx = CFG_KEY_LOW;
		cfg_data = '0;
		key_lo_q = '0;
		key_hi_q = '0;
		send_idle_pct = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table; row 0 relies on the reset key
		for (int v = 0; v < NUM_DIRECTED; v++) begin
			if (v > 0) begin
				drain_pipeline();
				write_key(CFG_KEY_LOW, vectors[v].k_lo);
				write_key(CFG_KEY_HIGH, vectors[v].k_hi);
			end
			send_block(vectors[v].blk, vectors[v].known ? vectors[v].cipher
				: encrypt_block(vectors[v].blk, key_lo_q, key_hi_q));
		end

		// Random phases with varying sender idling, key changed at each phase
		for (int ph = 0; ph < 8; ph++) begin
			drain_pipeline();
			send_idle_pct = idle_plan[ph % 4];
			case (ph)
				0: write_key(CFG_KEY_LOW, '1);
				1: write_key(CFG_KEY_HIGH, '0);
				default: begin
					write_key(CFG_KEY_LOW, rand64());
					write_key(CFG_KEY_HIGH, rand64());
				end
			endcase
			for (int n = 0; n < 88; n++) begin
				blk.plain_low = rand64();
				blk.plain_high = rand64();
				// occasional block with no gap regardless of phase
				send_idle_pct = ($urandom_range(9) == 0) ? 0 : idle_plan[ph % 4];
				send_block(blk, encrypt_block(blk, key_lo_q, key_hi_q));
			end
		end

		drain_pipeline();
		$display("Encrypted %0d blocks (%0d checked) over 8 directed keys and 8 random phases",
			blocks_sent, blocks_seen);
		if (mismatches == 0 && pending_cipher.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: filelist.f
design/aes_pkg.sv
design/aes_round_cell.sv
design/aes128_block_encrypt.sv
tb/sv/tb_aes128_block_encrypt.sv
